// ----- src/rre_pkg.sv -----
// rre_pkg: widths and defaults shared by the remove-repeated-elements block.
// No dependencies; compile first.
package rre_pkg;
	localparam int DATA_W           = 32;
	localparam int CNT_W            = 6;
	localparam int MAX_ELEMENTS_DEF = 32;
endpackage

// ----- src/rre_in_if.sv -----
// rre_in_if: valid/ready channel for input elements (value, last).
// Depends on rre_pkg.
interface rre_in_if import rre_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic                     last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- src/rre_out_if.sv -----
// rre_out_if: valid/ready channel for results (unique values, then a summary beat).
// Depends on rre_pkg.
interface rre_out_if import rre_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value_res;
	logic                     is_summary;
	logic [CNT_W-1:0]         repeat_count;
	logic                     overflow;
	logic                     last_res;

	modport source (output valid, output value_res, output is_summary,
		output repeat_count, output overflow, output last_res, input ready);
	modport sink   (input valid, input value_res, input is_summary,
		input repeat_count, input overflow, input last_res, output ready);
endinterface

// ----- src/remove_repeated_elements.sv -----
// remove_repeated_elements: top level; stores a set, emits values seen once, then a summary.
// Depends on rre_pkg, rre_in_if, rre_out_if.
//
//  channel | dir | payload                                              | last beat
//  din     | in  | value, last                                          | last = 1
//  dout    | out | value_res, is_summary, repeat_count, overflow, last_res | summary
//
// Loading accepts one beat per cycle. After the closing beat, each stored element i
// is checked against all N stored elements with one comparator fed from one
// memory read port, and a unique element then gets its own output beat.
// din is not ready while a set is evaluated.
// arst_n clears control state; the store is not cleared. dout stalls hold the sequencer.
module remove_repeated_elements import rre_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rre_in_if.sink    din,
	rre_out_if.source dout
);
	localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);
	localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_PIV   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;

	logic [DATA_W-1:0] mem [MAX_ELEMENTS];
	logic [DATA_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  rd_addr;

	logic [2:0]        state_q;
	logic [FILL_W-1:0] fill_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  dropped_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [DATA_W-1:0] pivot_q;
	logic              dup_q;
	logic              piv_s1;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;

	logic [DATA_W-1:0] val_res_q;
	logic              is_sum_q;
	logic [CNT_W-1:0]  rep_q;
	logic              ovf_out_q;

	logic              in_acc;
	logic              out_acc;
	logic              match;
	logic              dup_final;
	logic              last_i;
	logic              last_j;

	assign in_acc    = din.valid && din.ready;
	assign out_acc   = dout.valid && dout.ready;
	assign match     = cmp_vld_s1 && (cmp_idx_s1 != i_q) && (rd_data_q == pivot_q);
	assign dup_final = dup_q || match;
	assign last_i    = (FILL_W'(i_q) == fill_q - FILL_W'(1));
	assign last_j    = (FILL_W'(j_q) == fill_q - FILL_W'(1));
	assign rd_addr   = (state_q == ST_PIV) ? i_q : j_q;

	assign din.ready         = (state_q == ST_LOAD);
	assign dout.valid        = (state_q == ST_EMIT) || (state_q == ST_SUM);
	assign dout.value_res    = val_res_q;
	assign dout.is_summary   = is_sum_q;
	assign dout.repeat_count = rep_q;
	assign dout.overflow     = ovf_out_q;
	assign dout.last_res     = is_sum_q;

	// element store: one write port (load), one registered read port (scan)
	always_ff @(posedge clk) begin
		if (in_acc && (fill_q < FILL_W'(MAX_ELEMENTS))) begin
			mem[fill_q[IDX_W-1:0]] <= din.value;
		end
		rd_data_q <= mem[rd_addr];
	end

	// compare stage tracking and pivot capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piv_s1     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			piv_s1     <= (state_q == ST_PIV);
			cmp_vld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= j_q;
		if (piv_s1) begin
			pivot_q <= rd_data_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			fill_q    <= '0;
			ovf_q     <= 1'b0;
			dropped_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			dup_q     <= 1'b0;
			val_res_q <= '0;
			is_sum_q  <= 1'b0;
			rep_q     <= '0;
			ovf_out_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (fill_q < FILL_W'(MAX_ELEMENTS)) begin
							fill_q <= fill_q + FILL_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (din.last) begin
							i_q     <= '0;
							state_q <= ST_PIV;
						end
					end
				end
				ST_PIV: begin
					j_q     <= '0;
					dup_q   <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					dup_q <= dup_final;
					if (last_j) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (dup_final) begin
						dropped_q <= dropped_q + CNT_W'(1);
						if (last_i) begin
							val_res_q <= '0;
							is_sum_q  <= 1'b1;
							rep_q     <= dropped_q + CNT_W'(1);
							ovf_out_q <= ovf_q;
							state_q   <= ST_SUM;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_PIV;
						end
					end else begin
						val_res_q <= pivot_q;
						is_sum_q  <= 1'b0;
						rep_q     <= '0;
						ovf_out_q <= 1'b0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (last_i) begin
							val_res_q <= '0;
							is_sum_q  <= 1'b1;
							rep_q     <= dropped_q;
							ovf_out_q <= ovf_q;
							state_q   <= ST_SUM;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_PIV;
						end
					end
				end
				ST_SUM: begin
					if (out_acc) begin
						fill_q    <= '0;
						ovf_q     <= 1'b0;
						dropped_q <= '0;
						is_sum_q  <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end
endmodule

// ----- bench/tb_remove_repeated_elements.sv -----
`timescale 1ns / 100ps
// tb_remove_repeated_elements: directed table and random sets for remove_repeated_elements,
// scored beat by beat against typed rows or a built-in model of the unique-value filter.
// Depends on rre_pkg, rre_in_if, rre_out_if and the block itself.
module tb_remove_repeated_elements;
	import rre_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 347;
	localparam int TAIL_ITEMS   = 60;
	localparam int DIR_ROWS     = 23;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic                     is_summary;
		logic [CNT_W-1:0]         repeat_count;
		logic                     overflow;
		logic                     last_res;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     typed;
		logic                     exp_uniq;
		logic [CNT_W-1:0]         exp_rc;
		logic                     exp_ovf;
	} stim_row_t;

	logic clk;
	logic arst_n;

	rre_in_if  din_if ();
	rre_out_if dout_if ();

	remove_repeated_elements dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if.sink),
		.dout   (dout_if.source)
	);

	result_t                  pending_results [$];
	logic signed [DATA_W-1:0] set_store [MAX_ELEMENTS_DEF];
	int                       set_fill;
	logic                     set_dropped_any;
	stim_row_t                directed_rows [DIR_ROWS];

	int  err_count;
	int  items_sent;
	int  sets_closed;
	int  overflow_sets;
	int  beats_checked;
	int  stall_left;
	int  cycle_cnt;
	bit  tail_phase;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
			pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report(input string msg);
		err_count++;
		if (err_count <= 30)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Unique-value filter: store one element, close the set on last.
	task automatic model_element(input logic signed [DATA_W-1:0] v, input logic l,
		input bit push_results);
		int               hits;
		logic [CNT_W-1:0] dropped;
		result_t          r;
		if (set_fill < MAX_ELEMENTS_DEF) begin
			set_store[set_fill] = v;
			set_fill++;
		end else begin
			set_dropped_any = 1'b1;
		end
		if (!l)
			return;
		sets_closed++;
		if (set_dropped_any)
			overflow_sets++;
		dropped = '0;
		for (int i = 0; i < set_fill; i++) begin
			hits = 0;
			for (int j = 0; j < set_fill; j++)
				if (set_store[j] === set_store[i])
					hits++;
			if (hits == 1) begin
				r = '{set_store[i], 1'b0, '0, 1'b0, 1'b0};
				if (push_results)
					pending_results.push_back(r);
			end else begin
				dropped++;
			end
		end
		r = '{'0, 1'b1, dropped, set_dropped_any, 1'b1};
		if (push_results)
			pending_results.push_back(r);
		set_fill        = 0;
		set_dropped_any = 1'b0;
	endtask

	task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic l,
		input bit allow_gap);
		int gap;
		if (allow_gap && !tail_phase && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 9);
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value <= v;
		din_if.last  <= l;
		do @(posedge clk); while (!din_if.ready);
		items_sent++;
	endtask

	task automatic check_beat();
		result_t got;
		result_t want;
		got = '{dout_if.value_res, dout_if.is_summary, dout_if.repeat_count,
			dout_if.overflow, dout_if.last_res};
		beats_checked++;
		if (pending_results.size() == 0) begin
			report($sformatf("unexpected beat value_res=%0d is_summary=%0b",
				got.value_res, got.is_summary));
			return;
		end
		want = pending_results.pop_front();
		if (got.value_res !== want.value_res)
			report($sformatf("value_res %0d, want %0d", got.value_res, want.value_res));
		if (got.is_summary !== want.is_summary)
			report($sformatf("is_summary %0b, want %0b", got.is_summary, want.is_summary));
		if (got.repeat_count !== want.repeat_count)
			report($sformatf("repeat_count %0d, want %0d", got.repeat_count,
				want.repeat_count));
		if (got.overflow !== want.overflow)
			report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
		if (got.last_res !== want.last_res)
			report($sformatf("last_res %0b, want %0b", got.last_res, want.last_res));
	endtask

	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready)
			check_beat();
		if (tail_phase) begin
			stall_left = 0;
			dout_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			dout_if.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 15) begin
			stall_left = $urandom_range(1, 9) - 1;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= 1'b1;
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 11))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random_set(input int len);
		logic signed [DATA_W-1:0] pool [8];
		logic signed [DATA_W-1:0] v;
		int                       pool_n;
		bit                       use_pool;
		bit                       gaps_on;
		pool_n   = $urandom_range(1, 8);
		use_pool = ($urandom_range(0, 3) != 0);
		gaps_on  = ($urandom_range(0, 3) != 0);
		for (int k = 0; k < pool_n; k++)
			pool[k] = rand_word();
		for (int n = 0; n < len; n++) begin
			if (!use_pool)
				v = rand_word();
			else if ($urandom_range(0, 9) == 0)
				v = pool[$urandom_range(0, pool_n - 1)] ^ (32'sd1 << $urandom_range(0, 31));
			else
				v = pool[$urandom_range(0, pool_n - 1)];
			send_beat(v, n == len - 1, gaps_on);
			model_element(v, n == len - 1, 1'b1);
		end
	endtask

	initial begin
		stim_row_t row;
		int        len;
		int        pick;
		err_count       = 0;
		items_sent      = 0;
		sets_closed     = 0;
		overflow_sets   = 0;
		beats_checked   = 0;
		stall_left      = 0;
		tail_phase      = 1'b0;
		set_fill        = 0;
		set_dropped_any = 1'b0;
		arst_n          = 1'b0;
		din_if.valid    = 1'b0;
		din_if.value    = '0;
		din_if.last     = 1'b0;
		dout_if.ready   = 1'b0;

		// value, last, typed, exp_uniq, exp_rc, exp_ovf
		directed_rows = '{
			'{32'sh8000_0000, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0},
			'{32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0},
			'{32'sh0000_0000, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0},
			'{-32'sd1,        1'b1, 1'b1, 1'b1, 6'd0, 1'b0},
			'{32'sh8000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh8000_0000, 1'b1, 1'b1, 1'b0, 6'd2, 1'b0},
			'{32'sh0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh0000_0001, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh7FFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{-32'sd1,        1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sd5,         1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sd9,         1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sd5,         1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{-32'sd3,        1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sd9,         1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh0000_0000, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh0000_0000, 1'b1, 1'b1, 1'b0, 6'd4, 1'b0},
			'{32'shAAAA_AAAA, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh5555_5555, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'shAAAA_AAAA, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
			'{32'sh1234_5678, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			row = directed_rows[r];
			send_beat(row.value, row.last, 1'b1);
			model_element(row.value, row.last, !row.typed);
			if (row.typed) begin
				if (row.exp_uniq)
					pending_results.push_back('{row.value, 1'b0, '0, 1'b0, 1'b0});
				pending_results.push_back('{'0, 1'b1, row.exp_rc, row.exp_ovf, 1'b1});
			end
		end

		// store full: closing beat dropped, then four beats dropped, then filled exactly
		send_random_set(MAX_ELEMENTS_DEF + 1);
		send_random_set(MAX_ELEMENTS_DEF + 4);
		send_random_set(MAX_ELEMENTS_DEF);

		while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
			if (items_sent >= DIR_ROWS + RANDOM_ITEMS - TAIL_ITEMS)
				tail_phase = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				len = $urandom_range(1, 8);
			else if (pick < 80)
				len = $urandom_range(9, 24);
			else if (pick < 92)
				len = $urandom_range(25, MAX_ELEMENTS_DEF);
			else
				len = $urandom_range(MAX_ELEMENTS_DEF + 1, MAX_ELEMENTS_DEF + 8);
			send_random_set(len);
		end
		din_if.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d beats in, %0d sets closed (%0d with store full), %0d result beats checked",
			items_sent, sets_closed, overflow_sets, beats_checked);
		$display("%0d mismatches", err_count);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
